/* src/assert_macros.svh */
// Assertion macros shared by the RTL files that carry concurrent checks.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lrsi_pkg.sv */
// Shared constants and types of the Laguerre RSI filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package lrsi_pkg;
  localparam int PRICE_W     = 32;
  localparam int PRICE_FRAC  = 16;
  localparam int GAMMA_W     = 16;
  localparam int RSI_W       = 17;
  localparam int OUT_TDATA_W = 24;
  localparam int MUL_CHUNK   = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_STAGES  = 4;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'h8000;
  localparam logic [RSI_W-1:0]   RSI_HALF    = 17'h08000;

  typedef struct packed {
    logic held;
    logic seeded;
  } lrsi_flags_t;
endpackage

/* src/laguerre_rsi_filter_top.sv */
// Channel   Dir  Contents
// s_axis    in   tdata: close_price[31:0]
// m_axis    out  tdata: rsi_value[16:0], zero pad; tuser: seeded[0], held[1]
// cfg       in   cfg_wr_en / cfg_wr_data: gamma, Q0.16
//
// A normal word runs the chain of NUM_STAGES stages on the shared 32x16 multiplier, then
// the piles and the divider. A held word ends after the piles; a seeding word skips the
// chain, loads every stage with its price and goes straight to the output.
// Reset is synchronous: stages zero, last ratio 0.5, gamma 0.5, queue empty.
// A two-word queue decouples input from the engine; the output register holds under stall.
// Top level of the Laguerre RSI filter; depends on lrsi_pkg, lrsi_front, lrsi_queue,
// lrsi_div, lrsi_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module laguerre_rsi_filter_top #(
  parameter int STAGE_WIDTH = 48,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [lrsi_pkg::GAMMA_W-1:0]      cfg_wr_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lrsi_pkg::PRICE_W-1:0]      s_axis_tdata,   // close_price
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lrsi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // rsi_value, zero pad
  output logic [1:0]                        m_axis_tuser    // seeded, held
);
  import lrsi_pkg::*;

  localparam int QW = STAGE_WIDTH + 1;

  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;
  logic [STAGE_WIDTH-1:0] item_x;
  logic                   item_seed;
  logic [QW-1:0]          q_out;
  logic [RSI_W-1:0]       out_rsi;
  lrsi_flags_t            out_flags;

  lrsi_front #(
    .STAGE_WIDTH (STAGE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_price  (s_axis_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .item_x    (item_x),
    .item_seed (item_seed)
  );

  lrsi_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({item_seed, item_x}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  lrsi_back #(
    .STAGE_WIDTH (STAGE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_x         (q_out[STAGE_WIDTH-1:0]),
    .q_seed      (q_out[QW-1]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_rsi     (out_rsi),
    .out_flags   (out_flags)
  );

  assign m_axis_tdata = OUT_TDATA_W'(out_rsi);
  assign m_axis_tuser = out_flags;

  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst, q_pop, !q_empty, "pop from empty queue")
  `ASSERT_IMPLIES(a_push_not_full, clk, rst, q_push, !q_full, "push into full queue")
  `ASSERT_NEXT(a_accept_moves, clk, rst, s_axis_tvalid && s_axis_tready, q_push || q_full, "accepted word not forwarded")
  `ASSERT_IMPLIES(a_seed_half, clk, rst, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[RSI_W-1:0] == RSI_HALF, "seeding word not 0.5")
endmodule

/* src/lrsi_front.sv */
// Input side: takes price words, converts to stage format, flags the seeding word.
// Depends on lrsi_pkg; feeds lrsi_queue.
`timescale 1ns / 1ps
module lrsi_front #(
  parameter int STAGE_WIDTH = 48,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lrsi_pkg::PRICE_W-1:0]  in_price,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [STAGE_WIDTH-1:0]        item_x,
  output logic                          item_seed
);
  import lrsi_pkg::*;

  localparam int SHL   = (FRAC_BITS >= PRICE_FRAC) ? FRAC_BITS - PRICE_FRAC : 0;
  localparam int SHR   = (FRAC_BITS <  PRICE_FRAC) ? PRICE_FRAC - FRAC_BITS : 0;
  localparam int EXT_W = PRICE_W + SHL;
  localparam int CMP_W = (EXT_W > STAGE_WIDTH) ? EXT_W : STAGE_WIDTH;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'({1'b0, {(STAGE_WIDTH-1){1'b1}}});

  logic                   valid;
  logic                   started;
  logic [STAGE_WIDTH-1:0] x;
  logic                   seed;
  logic [EXT_W-1:0]       ext;
  logic [CMP_W-1:0]       ext_c;
  logic [STAGE_WIDTH-1:0] x_next;
  logic                   accept;

  always_comb begin
    ext    = (EXT_W'(in_price) << SHL) >> SHR;
    ext_c  = CMP_W'(ext);
    x_next = (ext_c > MAX_C) ? STAGE_WIDTH'(MAX_C) : STAGE_WIDTH'(ext_c);
  end

  assign in_ready  = !valid || !q_full;
  assign accept    = in_valid && in_ready;
  assign q_push    = valid && !q_full;
  assign item_x    = x;
  assign item_seed = seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      started <= 1'b0;
    end else if (accept) begin
      valid   <= 1'b1;
      x       <= x_next;
      seed    <= !started && (in_price != '0);
      started <= started || (in_price != '0);
    end else if (q_push) begin
      valid <= 1'b0;
    end
  end
endmodule

/* src/lrsi_queue.sv */
// Short queue between the input side and the filter engine.
// Depends on lrsi_pkg for its depth.
`timescale 1ns / 1ps
module lrsi_queue #(
  parameter int WIDTH = 49
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import lrsi_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end
endmodule

/* src/lrsi_div.sv */
// Restoring divider, one quotient bit per cycle, for the up/(up+down) ratio.
// Depends on lrsi_pkg; used by lrsi_back.
`timescale 1ns / 1ps
module lrsi_div #(
  parameter int W = 50
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [W-1:0]                num,
  input  logic [W-1:0]                den,
  output logic                        done,
  output logic [lrsi_pkg::RSI_W-1:0]  quot
);
  import lrsi_pkg::*;

  localparam int CNT_W = $clog2(RSI_W);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       p;
  logic [W:0]       d;
  logic [RSI_W-1:0] q;
  logic             ge;
  logic [W:0]       p_sub;

  always_comb begin
    ge    = (p >= d);
    p_sub = ge ? p - d : p;
  end

  assign quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        p   <= (W+1)'(num);
        d   <= (W+1)'(den);
      end else if (run) begin
        p   <= p_sub << 1;
        q   <= {q[RSI_W-2:0], ge};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(RSI_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* src/lrsi_back.sv */
// Filter engine: Laguerre chain on a shared chunked multiplier, piles, ratio, output word.
// Depends on lrsi_pkg and lrsi_div; reads words from lrsi_queue.
`timescale 1ns / 1ps
module lrsi_back #(
  parameter int STAGE_WIDTH = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lrsi_pkg::GAMMA_W-1:0]  cfg_wr_data,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [STAGE_WIDTH-1:0]        q_x,
  input  logic                          q_seed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lrsi_pkg::RSI_W-1:0]    out_rsi,
  output lrsi_pkg::lrsi_flags_t         out_flags
);
  import lrsi_pkg::*;

  localparam int DW     = STAGE_WIDTH + 1;
  localparam int NCHUNK = (DW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int XW     = NCHUNK * MUL_CHUNK;
  localparam int PW     = DW + GAMMA_W;
  localparam int SUM_W  = DW + 1;
  localparam int PILE_W = STAGE_WIDTH + 2;
  localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int IDX_W  = $clog2(NUM_STAGES);
  localparam logic [STAGE_WIDTH-1:0] MAX_S = {1'b0, {(STAGE_WIDTH-1){1'b1}}};
  localparam logic [STAGE_WIDTH-1:0] MIN_S = {1'b1, {(STAGE_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIFF, ST_MUL, ST_ADD, ST_PILE, ST_TOT, ST_DIV, ST_OUT
  } state_t;

  state_t                        state;
  logic [GAMMA_W-1:0]            gamma;
  logic signed [STAGE_WIDTH-1:0] s  [NUM_STAGES];
  logic signed [STAGE_WIDTH-1:0] nv [NUM_STAGES];
  logic signed [STAGE_WIDTH-1:0] x;
  logic signed [STAGE_WIDTH-1:0] base;
  logic [IDX_W-1:0]              idx;
  logic [IDX_W-1:0]              pk;
  logic [XW-1:0]                 dsh;
  logic [CNT_W-1:0]              cnt;
  logic signed [PW-1:0]          acc;
  logic signed [DW-1:0]          pd;
  logic [PILE_W-1:0]             up;
  logic [PILE_W-1:0]             down;
  logic [RSI_W-1:0]              last_rsi;
  logic [RSI_W-1:0]              res_rsi;
  lrsi_flags_t                   res_flags;
  logic                          div_start;

  logic [IDX_W-1:0]              idx_prev;
  logic [IDX_W-1:0]              pk_next;
  logic signed [DW-1:0]          d_next;
  logic [MUL_CHUNK-1:0]          chunk;
  logic signed [MUL_CHUNK+GAMMA_W:0] prod_s;
  logic [MUL_CHUNK+GAMMA_W-1:0]  prod_u;
  logic signed [PW-1:0]          acc_next;
  logic signed [SUM_W-1:0]       sum;
  logic [SUM_W-STAGE_WIDTH:0]    sum_hi;
  logic [STAGE_WIDTH-1:0]        sat;
  logic signed [DW-1:0]          pd_next;
  logic [PILE_W-1:0]             tot;
  logic                          div_done;
  logic [RSI_W-1:0]              div_q;

  always_comb begin
    idx_prev = idx - IDX_W'(1);
    pk_next  = pk + IDX_W'(1);
    d_next   = DW'(s[idx]) - DW'((idx == '0) ? x : nv[idx_prev]);
    chunk    = dsh[XW-1 -: MUL_CHUNK];
    prod_s   = $signed(chunk) * $signed({1'b0, gamma});
    prod_u   = chunk * gamma;
    if (cnt == '0) begin
      acc_next = PW'(prod_s);
    end else begin
      acc_next = (acc << MUL_CHUNK) + $signed(PW'(prod_u));
    end
    sum    = SUM_W'(base) + SUM_W'(acc >>> GAMMA_W);
    sum_hi = sum[SUM_W-1:STAGE_WIDTH-1];
    if ((&sum_hi) || !(|sum_hi)) begin
      sat = sum[STAGE_WIDTH-1:0];
    end else begin
      sat = sum[SUM_W-1] ? MIN_S : MAX_S;
    end
    pd_next = DW'(nv[pk]) - DW'(nv[pk_next]);
    tot     = up + down;
  end

  assign q_pop = (state == ST_IDLE) && !q_empty;

  lrsi_div #(
    .W (PILE_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (up),
    .den   (tot),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gamma     <= GAMMA_RESET;
      last_rsi  <= RSI_HALF;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      for (int i = 0; i < NUM_STAGES; i++) begin
        s[i] <= '0;
      end
    end else begin
      div_start <= 1'b0;
      if (cfg_wr_en) begin
        gamma <= cfg_wr_data;
      end
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            x <= q_x;
            if (q_seed) begin
              for (int i = 0; i < NUM_STAGES; i++) begin
                s[i] <= q_x;
              end
              res_rsi   <= RSI_HALF;
              res_flags <= '{held: 1'b0, seeded: 1'b1};
              state     <= ST_OUT;
            end else begin
              idx   <= '0;
              state <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          base  <= (idx == '0) ? x : s[idx_prev];
          dsh   <= XW'(d_next);
          cnt   <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          acc <= acc_next;
          dsh <= dsh << MUL_CHUNK;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(NCHUNK - 1)) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          nv[idx] <= sat;
          if (idx == IDX_W'(NUM_STAGES - 1)) begin
            for (int i = 0; i < NUM_STAGES - 1; i++) begin
              s[i] <= nv[i];
            end
            s[NUM_STAGES-1] <= sat;
            pk    <= '0;
            up    <= '0;
            down  <= '0;
            state <= ST_PILE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= ST_DIFF;
          end
        end
        ST_PILE: begin
          pd <= pd_next;
          if (pk != '0) begin
            if (pd[DW-1]) begin
              down <= down - PILE_W'(pd);
            end else begin
              up <= up + PILE_W'(pd);
            end
          end
          pk <= pk_next;
          if (pk == IDX_W'(NUM_STAGES - 1)) begin
            state <= ST_TOT;
          end
        end
        ST_TOT: begin
          if (up == '0 && down == '0) begin
            res_rsi   <= last_rsi;
            res_flags <= '{held: 1'b1, seeded: 1'b0};
            state     <= ST_OUT;
          end else begin
            div_start <= 1'b1;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_rsi   <= div_q;
            last_rsi  <= div_q;
            res_flags <= '{held: 1'b0, seeded: 1'b0};
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_rsi   <= res_rsi;
            out_flags <= res_flags;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

/* bench/tb_laguerre_rsi_filter_top.sv */
// Self-checking bench for laguerre_rsi_filter_top: streams closing prices, predicts every
// ratio word with a bit-exact model of the Laguerre chain and compares it on the output.
// Depends on lrsi_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_laguerre_rsi_filter_top;
  import lrsi_pkg::*;

  localparam int STAGE_WIDTH = 48;
  localparam int FRAC_BITS   = 16;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 8;
  localparam int HOLD_OFF    = 1500;

  localparam logic signed [127:0] STAGE_HI = (128'sd1 <<< (STAGE_WIDTH - 1)) - 128'sd1;
  localparam logic signed [127:0] STAGE_LO = -(128'sd1 <<< (STAGE_WIDTH - 1));

  typedef logic signed [STAGE_WIDTH-1:0] stage_t;

  typedef struct packed {
    logic [RSI_W-1:0] rsi;
    logic             seeded;
    logic             held;
  } rsi_result_t;

  typedef enum logic [1:0] {FEED_PRICE, FEED_GAMMA, FEED_DRAIN} feed_kind_t;

  typedef struct packed {
    feed_kind_t        kind;
    logic [PRICE_W-1:0] value;
  } feed_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [GAMMA_W-1:0]     cfg_wr_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PRICE_W-1:0]     s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;

  feed_t       price_feed_q[$];
  rsi_result_t rsi_expect_q[$];

  stage_t           lag_stage[NUM_STAGES];
  logic             chain_started = 1'b0;
  logic [RSI_W-1:0] last_ratio = RSI_HALF;
  logic [GAMMA_W-1:0] gamma_model = GAMMA_RESET;

  int unsigned words_in = 0;
  int unsigned words_issued = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_cnt = 0;

  int burst_left = 0;
  int gap_left = 0;
  int settle_left = SETTLE;

  int hold_off_left = 0;
  int hold_offs_done = 0;
  int ready_mode = 0;
  int mode_left = 0;

  laguerre_rsi_filter_top #(
    .STAGE_WIDTH (STAGE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic stage_t clamp_stage(input logic signed [127:0] v);
    if (v > STAGE_HI) begin
      return stage_t'(STAGE_HI[STAGE_WIDTH-1:0]);
    end else if (v < STAGE_LO) begin
      return stage_t'(STAGE_LO[STAGE_WIDTH-1:0]);
    end
    return stage_t'(v[STAGE_WIDTH-1:0]);
  endfunction

  task automatic laguerre_predict(input logic [PRICE_W-1:0] price, output rsi_result_t r);
    logic signed [127:0] x, g, cg, acc, a, b, c, d;
    logic [127:0] cu, cd, tot, q;
    stage_t nxt[NUM_STAGES];
    int i;
    x = {96'b0, price} <<< (FRAC_BITS - PRICE_FRAC);
    g = {112'b0, gamma_model};
    cg = 128'sd65536 - g;
    cu = '0;
    cd = '0;
    if (!chain_started && price != '0) begin
      for (i = 0; i < NUM_STAGES; i++) lag_stage[i] = clamp_stage(x);
      chain_started = 1'b1;
      r = '{rsi: RSI_HALF, seeded: 1'b1, held: 1'b0};
    end else begin
      a = lag_stage[0];
      acc = x * cg + a * g;
      nxt[0] = clamp_stage(acc >>> 16);
      for (i = 1; i < NUM_STAGES; i++) begin
        a = lag_stage[i-1];
        b = nxt[i-1];
        c = lag_stage[i];
        acc = a * 128'sd65536 - b * g + c * g;
        nxt[i] = clamp_stage(acc >>> 16);
      end
      for (i = 0; i < NUM_STAGES; i++) lag_stage[i] = nxt[i];
      for (i = 0; i < NUM_STAGES - 1; i++) begin
        a = nxt[i];
        b = nxt[i+1];
        d = a - b;
        if (d < 0) cd = cd + (-d);
        else cu = cu + d;
      end
      tot = cu + cd;
      if (tot == '0) begin
        r = '{rsi: last_ratio, seeded: 1'b0, held: 1'b1};
      end else begin
        q = (cu << 16) / tot;
        last_ratio = q[RSI_W-1:0];
        r = '{rsi: last_ratio, seeded: 1'b0, held: 1'b0};
      end
    end
  endtask

  task automatic push_price(input logic [PRICE_W-1:0] p);
    price_feed_q.push_back('{kind: FEED_PRICE, value: p});
  endtask

  task automatic push_gamma(input logic [GAMMA_W-1:0] gv);
    price_feed_q.push_back('{kind: FEED_GAMMA, value: {16'b0, gv}});
  endtask

  task automatic push_drain();
    price_feed_q.push_back('{kind: FEED_DRAIN, value: '0});
  endtask

  task automatic add_price_phase(input logic [GAMMA_W-1:0] gv, input int count);
    longint prev, t, span;
    int n, sel, run, k;
    push_drain();
    push_gamma(gv);
    prev = $urandom;
    case ($urandom_range(0, 2))
      0: span = 16;
      1: span = 4096;
      default: span = 1 << 18;
    endcase
    n = 0;
    while (n < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        t = prev + longint'($urandom_range(0, 2 * span)) - span;
        if (t < 0) t = 0;
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        prev = t;
        push_price(t[31:0]);
        n++;
      end else if (sel < 75) begin
        run = $urandom_range(2, 6);
        for (k = 0; k < run; k++) push_price(prev[31:0]);
        n += run;
      end else if (sel < 88) begin
        prev = $urandom;
        push_price(prev[31:0]);
        n++;
      end else if (sel < 93) begin
        push_price('0);
        n++;
      end else if (sel < 98) begin
        push_price(32'hFFFF_FFFF);
        n++;
      end else begin
        push_drain();
      end
    end
  endtask

  // driver: prices, gamma writes and drain points from the feed queue
  always @(negedge clk) begin : price_driver
    feed_t              f;
    logic               nv;
    logic [PRICE_W-1:0] nd;
    logic               ncfg;
    logic [GAMMA_W-1:0] ncd;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    ncfg = 1'b0;
    ncd = cfg_wr_data;
    if (!rst && !(s_axis_tvalid && words_in != words_issued)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (price_feed_q.size() > 0) begin
        f = price_feed_q[0];
        case (f.kind)
          FEED_PRICE: begin
            void'(price_feed_q.pop_front());
            nv = 1'b1;
            nd = f.value;
            words_issued++;
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              case ($urandom_range(0, 9))
                0: begin
                  burst_left = $urandom_range(100, 250);
                  gap_left = 0;
                end
                1, 2, 3, 4: begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = $urandom_range(0, 3);
                end
                default: begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = $urandom_range(4, 60);
                end
              endcase
            end
          end
          FEED_GAMMA: begin
            if (rsi_expect_q.size() == 0 && words_in == words_issued) begin
              if (settle_left > 0) begin
                settle_left--;
              end else begin
                void'(price_feed_q.pop_front());
                ncfg = 1'b1;
                ncd = f.value[GAMMA_W-1:0];
                settle_left = SETTLE;
              end
            end
          end
          default: begin
            if (rsi_expect_q.size() == 0 && words_in == words_issued) begin
              void'(price_feed_q.pop_front());
            end
          end
        endcase
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
    cfg_wr_en <= ncfg;
    cfg_wr_data <= ncd;
  end

  always @(negedge clk) begin : ratio_sink
    logic rdy;
    if (hold_off_left > 0) begin
      hold_off_left--;
      rdy = 1'b0;
    end else if (hold_offs_done < 2 && results_seen >= 300 * (hold_offs_done + 1)) begin
      hold_off_left = HOLD_OFF;
      hold_offs_done++;
      rdy = 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      case (ready_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = mode_left[0];
      endcase
    end
    m_axis_tready <= rdy;
  end

  always @(posedge clk) begin : ratio_monitor
    rsi_result_t e;
    lrsi_flags_t flags;
    if (!rst) begin
      if (cfg_wr_en) gamma_model = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        laguerre_predict(s_axis_tdata, e);
        rsi_expect_q.push_back(e);
        words_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        flags = m_axis_tuser;
        if (rsi_expect_q.size() == 0) begin
          $error("unexpected word: rsi_value %0d", m_axis_tdata[RSI_W-1:0]);
          fail_count++;
        end else begin
          e = rsi_expect_q.pop_front();
          if (m_axis_tdata[RSI_W-1:0] !== e.rsi) begin
            $error("rsi_value: expected %0d, got %0d", e.rsi, m_axis_tdata[RSI_W-1:0]);
            fail_count++;
          end
          if (flags.seeded !== e.seeded) begin
            $error("seeded: expected %0b, got %0b", e.seeded, flags.seeded);
            fail_count++;
          end
          if (flags.held !== e.held) begin
            $error("held: expected %0b, got %0b", e.held, flags.held);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("laguerre_rsi_filter_top regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_STAGES; i++) lag_stage[i] = '0;

    push_gamma(16'h8000);
    push_price('0);
    push_price('0);
    push_price(32'd100 << 16);
    push_price(32'd100 << 16);
    push_price(32'hFFFF_FFFF);
    push_price('0);
    push_price(32'h0000_0001);
    push_price(32'h8000_0000);
    push_price(32'h7FFF_FFFF);
    push_price(32'hAAAA_AAAA);
    push_price(32'h5555_5555);
    push_drain();
    push_gamma(16'h0000);
    for (int i = 0; i < 5; i++) push_price(32'h0001_0000);
    push_price(32'h0002_0000);
    push_price(32'h0003_0000);
    push_price(32'h0001_8000);
    push_drain();
    push_gamma(16'hFFFF);
    push_price(32'hFFFF_FFFF);
    push_price('0);
    push_price(32'hFFFF_FFFF);
    push_price(32'h0000_0001);

    add_price_phase(16'hFFFF, 280);
    add_price_phase(16'h0000, 280);
    add_price_phase(16'($urandom_range(0, 65535)), 280);
    add_price_phase(16'h0001, 280);
    add_price_phase(16'h8000, 280);
    add_price_phase(16'($urandom_range(40000, 65535)), 280);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(price_feed_q.size() == 0 && words_in == words_issued &&
             rsi_expect_q.size() == 0)) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);

    if (fail_count == 0 && rsi_expect_q.size() == 0) begin
      $display("laguerre_rsi_filter_top regression: pass");
    end else begin
      $display("laguerre_rsi_filter_top regression: fail");
    end
    $finish;
  end
endmodule
